@@ rtl/sffe_pkg.sv @@
// Package for the sensor frame field extractor.
// Holds frame offsets, header bytes, record kinds and the result record type.
// No dependencies.
package sffe_pkg;

  // Frame offsets of the fixed fields.
  localparam logic [7:0] POS_HDR_END   = 8'd4;
  localparam logic [7:0] POS_CMD_LO    = 8'd4;
  localparam logic [7:0] POS_CMD_HI    = 8'd5;
  localparam logic [7:0] POS_LEN_LO    = 8'd6;
  localparam logic [7:0] POS_LEN_HI    = 8'd7;
  localparam logic [7:0] POS_SER_HI    = 8'd8;
  localparam logic [7:0] POS_SER_MID   = 8'd9;
  localparam logic [7:0] POS_SER_LO    = 8'd10;
  localparam logic [7:0] POS_BAT_LO    = 8'd11;
  localparam logic [7:0] POS_BAT_HI    = 8'd12;
  localparam logic [7:0] POS_EEG_START = 8'd73;
  localparam logic [7:0] POS_EEG_END   = 8'd143;
  localparam logic [7:0] POS_PROBE     = 8'd143;
  localparam logic [7:0] POS_GRAV_LO   = 8'd160;
  localparam logic [7:0] POS_GRAV_MID  = 8'd161;
  localparam logic [7:0] POS_GRAV_HI   = 8'd162;
  localparam logic [7:0] POS_CHK_LO    = 8'd185;
  localparam logic [7:0] POS_CHK_HI    = 8'd186;
  localparam logic [7:0] POS_MAX       = 8'd255;

  // Last-byte offsets for the length tests (length = offset + 1).
  localparam logic [7:0] POS_MIN_VALID = 8'd162;
  localparam logic [7:0] POS_MIN_CHECK = 8'd186;

  // EEG window: six stored bytes, then the event byte.
  localparam int unsigned   WIN_STORE = 6;
  localparam logic [2:0]    WIN_LAST  = 3'd6;

  // Record kinds.
  typedef enum logic [1:0] {
    KIND_SAMPLE    = 2'd0,
    KIND_CHECKED   = 2'd1,
    KIND_UNCHECKED = 2'd2,
    KIND_INVALID   = 2'd3
  } kind_t;

  // One result record.
  typedef struct packed {
    kind_t       record_kind;
    logic [27:0] channel_one;
    logic [27:0] channel_two;
    logic [7:0]  event_mark;
    logic [15:0] command_word;
    logic [15:0] declared_length;
    logic [23:0] serial_number;
    logic [15:0] battery_level;
    logic        probe_off;
    logic [23:0] gravity_value;
    logic [15:0] check_word;
    logic        last_of_run;
  } result_t;

  // Expected header byte at offsets 0 to 3.
  function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
    logic [7:0] val;
    case (idx)
      2'd0:    val = 8'h41;
      2'd1:    val = 8'h49;
      2'd2:    val = 8'h52;
      default: val = 8'h90;
    endcase
    return val;
  endfunction

  // A 24-bit value times ten, as two shifted adds.
  function automatic logic [27:0] times_ten(input logic [23:0] val);
    logic [27:0] ext;
    ext = {4'b0, val};
    return (ext << 3) + (ext << 1);
  endfunction

endpackage

@@ rtl/sensor_frame_field_extractor_unit.sv @@
// Sensor frame field extractor, top level.
// Depends on sffe_pkg for offsets, record kinds and the result record.
//
// Usage:
// Frame bytes enter on the in_ channel, one beat per byte, with
// in_frame_end high on the last byte of a frame. Records leave on the out_
// channel: an EEG sample for each complete 7-byte window in bytes 73 to 142
// of a frame whose header matched, and one summary record at each frame end.
// out_last_of_run marks the final record caused by one input beat.
// The first record of a beat goes into the output register when that is
// free, else into the queue behind it. Throughput: one byte per cycle while
// out_stall stays low; a frame-end byte that also completes a window makes
// two records and stalls the input until the second one has left the queue.
// The field logic is one pass per byte between the frame state registers and
// the output register; a two-entry queue behind the output register holds
// records that cannot leave yet, and the input stalls while it is not empty.
// When the receiver stalls, the output record holds. The input keeps taking
// beats that make no record and stalls after the first beat that makes one.
// Reset (synchronous, rst_n low) empties the output side and returns the
// frame state to the start of a frame with the header assumed matched.
module sensor_frame_field_extractor_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_end,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_record_kind,
  output logic [27:0] out_channel_one,
  output logic [27:0] out_channel_two,
  output logic [7:0]  out_event_mark,
  output logic [15:0] out_command_word,
  output logic [15:0] out_declared_length,
  output logic [23:0] out_serial_number,
  output logic [15:0] out_battery_level,
  output logic        out_probe_off,
  output logic [23:0] out_gravity_value,
  output logic [15:0] out_check_word,
  output logic        out_last_of_run
);

  // Frame state.
  logic [7:0]  pos_r, pos_nxt;
  logic        hdr_ok_r, hdr_ok_nxt;
  logic [15:0] cmd_r, cmd_nxt;
  logic [15:0] len_r, len_nxt;
  logic [23:0] ser_r, ser_nxt;
  logic [15:0] bat_r, bat_nxt;
  logic        probe_r, probe_nxt;
  logic [23:0] grav_r, grav_nxt;
  logic [15:0] chk_r, chk_nxt;
  logic [2:0]  win_idx_r, win_idx_nxt;
  logic [7:0]  win_r [sffe_pkg::WIN_STORE];

  // Output side.
  sffe_pkg::result_t out_r, out_nxt;
  logic              out_v_r, out_v_nxt;
  sffe_pkg::result_t q0_r, q0_nxt, q1_r, q1_nxt;
  logic [1:0]        q_cnt_r, q_cnt_nxt;

  // Per-beat results.
  sffe_pkg::result_t sample, summary, res0, res1;
  logic              in_eeg, do_sample, valid_frame, has_check;
  logic [1:0]        n_res;
  logic              acc, take, out_free;

  assign in_stall = (q_cnt_r != 2'd0);
  assign acc      = in_valid & ~in_stall;
  assign take     = out_v_r & ~out_stall;
  assign out_free = ~out_v_r | take;

  assign in_eeg    = (pos_r >= sffe_pkg::POS_EEG_START) && (pos_r < sffe_pkg::POS_EEG_END);
  assign do_sample = in_eeg && (win_idx_r == sffe_pkg::WIN_LAST) && hdr_ok_r;

  // Field capture at fixed offsets, summary, and clear at frame end.
  always_comb begin
    pos_nxt     = pos_r;
    hdr_ok_nxt  = hdr_ok_r;
    cmd_nxt     = cmd_r;
    len_nxt     = len_r;
    ser_nxt     = ser_r;
    bat_nxt     = bat_r;
    probe_nxt   = probe_r;
    grav_nxt    = grav_r;
    chk_nxt     = chk_r;
    win_idx_nxt = win_idx_r;

    if (pos_r < sffe_pkg::POS_HDR_END) begin
      if (in_data_byte != sffe_pkg::hdr_byte(pos_r[1:0])) begin
        hdr_ok_nxt = 1'b0;
      end
    end else if (in_eeg) begin
      win_idx_nxt = (win_idx_r == sffe_pkg::WIN_LAST) ? 3'd0 : win_idx_r + 3'd1;
    end else begin
      case (pos_r)
        sffe_pkg::POS_CMD_LO:   cmd_nxt[7:0]    = in_data_byte;
        sffe_pkg::POS_CMD_HI:   cmd_nxt[15:8]   = in_data_byte;
        sffe_pkg::POS_LEN_LO:   len_nxt[7:0]    = in_data_byte;
        sffe_pkg::POS_LEN_HI:   len_nxt[15:8]   = in_data_byte;
        sffe_pkg::POS_SER_HI:   ser_nxt[23:16]  = in_data_byte;
        sffe_pkg::POS_SER_MID:  ser_nxt[15:8]   = in_data_byte;
        sffe_pkg::POS_SER_LO:   ser_nxt[7:0]    = in_data_byte;
        sffe_pkg::POS_BAT_LO:   bat_nxt[7:0]    = in_data_byte;
        sffe_pkg::POS_BAT_HI:   bat_nxt[15:8]   = in_data_byte;
        sffe_pkg::POS_PROBE:    probe_nxt       = (in_data_byte != 8'd0);
        sffe_pkg::POS_GRAV_LO:  grav_nxt[7:0]   = in_data_byte;
        sffe_pkg::POS_GRAV_MID: grav_nxt[15:8]  = in_data_byte;
        sffe_pkg::POS_GRAV_HI:  grav_nxt[23:16] = in_data_byte;
        sffe_pkg::POS_CHK_LO:   chk_nxt[7:0]    = in_data_byte;
        sffe_pkg::POS_CHK_HI:   chk_nxt[15:8]   = in_data_byte;
        default: ;
      endcase
    end

    // The summary sees the fields including this byte.
    valid_frame = hdr_ok_nxt && (pos_r >= sffe_pkg::POS_MIN_VALID);
    has_check   = (pos_r >= sffe_pkg::POS_MIN_CHECK);
    summary     = '0;
    summary.last_of_run = 1'b1;
    if (valid_frame) begin
      summary.record_kind     = has_check ? sffe_pkg::KIND_CHECKED : sffe_pkg::KIND_UNCHECKED;
      summary.command_word    = cmd_nxt;
      summary.declared_length = len_nxt;
      summary.serial_number   = ser_nxt;
      summary.battery_level   = bat_nxt;
      summary.probe_off       = probe_nxt;
      summary.gravity_value   = grav_nxt;
      summary.check_word      = has_check ? chk_nxt : 16'd0;
    end else begin
      summary.record_kind = sffe_pkg::KIND_INVALID;
    end

    // Frame end returns the per-frame state to its start values.
    if (in_frame_end) begin
      pos_nxt     = 8'd0;
      hdr_ok_nxt  = 1'b1;
      cmd_nxt     = '0;
      len_nxt     = '0;
      ser_nxt     = '0;
      bat_nxt     = '0;
      probe_nxt   = 1'b0;
      grav_nxt    = '0;
      chk_nxt     = '0;
      win_idx_nxt = 3'd0;
    end else if (pos_r != sffe_pkg::POS_MAX) begin
      pos_nxt = pos_r + 8'd1;
    end
  end

  // EEG sample from the six stored window bytes and the event byte.
  always_comb begin
    sample             = '0;
    sample.record_kind = sffe_pkg::KIND_SAMPLE;
    sample.channel_one = sffe_pkg::times_ten({win_r[2], win_r[1], win_r[0]});
    sample.channel_two = sffe_pkg::times_ten({win_r[5], win_r[4], win_r[3]});
    sample.event_mark  = in_data_byte;
    sample.last_of_run = ~in_frame_end;
  end

  // Order the results of this beat: sample first, then summary.
  always_comb begin
    res0  = do_sample ? sample : summary;
    res1  = summary;
    n_res = {1'b0, do_sample} + {1'b0, in_frame_end};
  end

  // Output register and the queue behind it.
  always_comb begin
    out_nxt   = out_r;
    out_v_nxt = out_v_r & ~take;
    q0_nxt    = q0_r;
    q1_nxt    = q1_r;
    q_cnt_nxt = q_cnt_r;
    if (q_cnt_r != 2'd0) begin
      if (out_free) begin
        out_nxt   = q0_r;
        out_v_nxt = 1'b1;
        q0_nxt    = q1_r;
        q_cnt_nxt = q_cnt_r - 2'd1;
      end
    end else if (acc && (n_res != 2'd0)) begin
      if (out_free) begin
        out_nxt   = res0;
        out_v_nxt = 1'b1;
        q0_nxt    = res1;
        q_cnt_nxt = n_res - 2'd1;
      end else begin
        q0_nxt    = res0;
        q1_nxt    = res1;
        q_cnt_nxt = n_res;
      end
    end
  end

  // Control and frame state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= 8'd0;
      hdr_ok_r  <= 1'b1;
      cmd_r     <= '0;
      len_r     <= '0;
      ser_r     <= '0;
      bat_r     <= '0;
      probe_r   <= 1'b0;
      grav_r    <= '0;
      chk_r     <= '0;
      win_idx_r <= 3'd0;
      out_v_r   <= 1'b0;
      q_cnt_r   <= 2'd0;
    end else begin
      out_v_r <= out_v_nxt;
      q_cnt_r <= q_cnt_nxt;
      if (acc) begin
        pos_r     <= pos_nxt;
        hdr_ok_r  <= hdr_ok_nxt;
        cmd_r     <= cmd_nxt;
        len_r     <= len_nxt;
        ser_r     <= ser_nxt;
        bat_r     <= bat_nxt;
        probe_r   <= probe_nxt;
        grav_r    <= grav_nxt;
        chk_r     <= chk_nxt;
        win_idx_r <= win_idx_nxt;
      end
    end
  end

  // Payload registers: output record, queue and window bytes.
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    q0_r  <= q0_nxt;
    q1_r  <= q1_nxt;
    if (acc && in_eeg && (win_idx_r != sffe_pkg::WIN_LAST)) begin
      win_r[win_idx_r] <= in_data_byte;
    end
  end

  // Output ports.
  assign out_valid           = out_v_r;
  assign out_record_kind     = out_r.record_kind;
  assign out_channel_one     = out_r.channel_one;
  assign out_channel_two     = out_r.channel_two;
  assign out_event_mark      = out_r.event_mark;
  assign out_command_word    = out_r.command_word;
  assign out_declared_length = out_r.declared_length;
  assign out_serial_number   = out_r.serial_number;
  assign out_battery_level   = out_r.battery_level;
  assign out_probe_off       = out_r.probe_off;
  assign out_gravity_value   = out_r.gravity_value;
  assign out_check_word      = out_r.check_word;
  assign out_last_of_run     = out_r.last_of_run;

endmodule
